@@ src/chained_hash_table_defines.svh @@
// Assertion helpers used by the controller
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
// Implication that is checked on every clock edge outside reset
`define CHT_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Plain condition checked on every clock edge
`define CHT_ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

@@ src/cht_pkg.sv @@
package cht_pkg;
   localparam int DEF_BUCKETS    = 16;
   localparam int DEF_POOL_NODES = 64;
   localparam int KEY_W          = 31;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_FOUND    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, start bucket hash
      logic bkt;        // register bucket, read head
      logic rd_node;    // load cur from the head read
      logic step;       // advance prev/cur along the chain
      logic ins;        // link new node at head
      logic del;        // unlink cur
      logic clr;        // clearing pass write
      logic clr_first;  // start clearing pass
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cur_nil;
      logic match;
      logic pool_empty;
      logic clr_last;
      logic walk_limit;
   } sts_type;
endpackage

@@ src/cht_ram.sv @@
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

@@ src/cht_datapath.sv @@
module cht_datapath #(
   parameter int BUCKETS    = 16,
   parameter int POOL_NODES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_operation,
   input  logic [cht_pkg::KEY_W-1:0] req_key,
   input  cht_pkg::cmd_type       cmd,
   output cht_pkg::sts_type       sts,
   output logic [1:0]             op_q,
   output logic [cht_pkg::KEY_W-1:0] key_q
);
   import cht_pkg::*;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = $clog2(POOL_NODES);
   localparam int PW = NW + 1;   // node index plus empty mark
   localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
   localparam int CW = ((BW > NW) ? BW : NW) + 1;
   localparam int RW = KEY_W + 2;   // reciprocal width
   localparam int MW = KEY_W + RW;  // product width
   localparam logic [RW-1:0] RECIP = RW'((MW'(1) << (KEY_W + BW)) / MW'(BUCKETS));

   logic [1:0]       op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [BW-1:0]    bkt_ff;
   logic [PW-1:0]    cur_ff, prev_ff;
   logic [PW-1:0]    fcnt_ff;
   logic [PW-1:0]    steps_ff;
   logic [CW-1:0]    clr_ff;
   logic [MW-1:0]    prod_ff;
   logic [BW:0]      q_lo, qb, rem;
   logic [BW-1:0]    bkt_calc;

   // bucket = key mod BUCKETS by reciprocal multiply; quotient estimate is low by
   // at most one, so the low bits and one compare and subtract give the remainder
   assign q_lo = prod_ff[KEY_W+BW +: BW+1];
   assign qb   = (BW+1)'(q_lo * (BW+1)'(BUCKETS));
   assign rem  = key_ff[BW:0] - qb;
   assign bkt_calc = (rem >= (BW+1)'(BUCKETS)) ? BW'(rem - (BW+1)'(BUCKETS))
                                                : rem[BW-1:0];

   logic [KEY_W-1:0] nk_rd;
   logic [PW-1:0]    nl_rd, hd_rd, fs_rd;
   logic             hd_we, nk_we, nl_we, fs_we;
   logic [BW-1:0]    hd_wa, hd_ra;
   logic [PW-1:0]    hd_wd, nl_wd;
   logic [NW-1:0]    nl_wa, nk_ra, fs_wa, fs_ra;
   logic [NW-1:0]    fs_wd;

   // head read once the bucket is known, or reread of current bucket
   assign hd_ra = cmd.bkt ? bkt_calc : bkt_ff;
   assign nk_ra = cur_ff[NW-1:0];
   assign fs_ra = NW'(fcnt_ff - PW'(1));

   always_comb begin
      hd_we = 1'b0; hd_wa = bkt_ff; hd_wd = NIL;
      nl_we = 1'b0; nl_wa = cur_ff[NW-1:0]; nl_wd = NIL;
      nk_we = 1'b0;
      fs_we = 1'b0; fs_wa = clr_ff[NW-1:0]; fs_wd = clr_ff[NW-1:0];
      if (cmd.clr) begin
         hd_we = (clr_ff < CW'(BUCKETS)); hd_wa = clr_ff[BW-1:0];
         fs_we = (clr_ff < CW'(POOL_NODES));
      end else if (cmd.ins) begin
         nk_we = 1'b1;
         nl_we = 1'b1; nl_wa = fs_rd[NW-1:0]; nl_wd = hd_rd;
         hd_we = 1'b1; hd_wd = fs_rd;
      end else if (cmd.del) begin
         if (prev_ff == NIL) begin
            hd_we = 1'b1; hd_wd = nl_rd;
         end else begin
            nl_we = 1'b1; nl_wa = prev_ff[NW-1:0]; nl_wd = nl_rd;
         end
         fs_we = 1'b1; fs_wa = fcnt_ff[NW-1:0]; fs_wd = cur_ff[NW-1:0];
      end
   end

   cht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
      .clock, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
   cht_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_key (
      .clock, .we(nk_we), .waddr(fs_rd[NW-1:0]), .wdata(key_ff), .raddr(nk_ra),
      .rdata(nk_rd));
   cht_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_link (
      .clock, .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(nk_ra), .rdata(nl_rd));
   cht_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_free (
      .clock, .we(fs_we), .waddr(fs_wa), .wdata(PW'(fs_wd)), .raddr(fs_ra),
      .rdata(fs_rd));

   // walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= PW'(POOL_NODES);
         clr_ff  <= '0;
      end else begin
         if (cmd.clr_first) clr_ff <= '0;
         else if (cmd.clr) clr_ff <= clr_ff + CW'(1);
         if (cmd.ins) fcnt_ff <= fcnt_ff - PW'(1);
         else if (cmd.del) fcnt_ff <= fcnt_ff + PW'(1);
      end
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         prod_ff <= MW'(req_key) * MW'(RECIP);
         prev_ff <= NIL;
         steps_ff <= '0;
      end
      if (cmd.bkt) bkt_ff <= bkt_calc;
      // head read arrives in the cycle after the bucket
      if (cmd.rd_node && steps_ff == '0 && !cmd.step) cur_ff <= hd_rd;
      if (cmd.step) begin
         prev_ff  <= cur_ff;
         cur_ff   <= nl_rd;
         steps_ff <= steps_ff + PW'(1);
      end
   end

   assign sts.cur_nil    = (cur_ff >= NIL);
   assign sts.match      = (nk_rd == key_ff);
   assign sts.pool_empty = (fcnt_ff == '0);
   assign sts.clr_last   = (clr_ff == CW'((BUCKETS > POOL_NODES ? BUCKETS : POOL_NODES) - 1));
   assign sts.walk_limit = (steps_ff >= PW'(POOL_NODES));
   assign op_q  = op_ff;
   assign key_q = key_ff;
endmodule

@@ src/cht_ctrl.sv @@
module cht_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [cht_pkg::KEY_W-1:0] rsp_found_value,
   input  logic [1:0]                op_q,
   input  logic [cht_pkg::KEY_W-1:0] key_q,
   input  cht_pkg::sts_type          sts,
   output cht_pkg::cmd_type          cmd
);
   import cht_pkg::*;
   `include "chained_hash_table_defines.svh"

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_BKT, S_HEAD, S_CUR, S_CHECK, S_INSERT, S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_valid_ff;
   logic             rsp_load;
   logic [1:0]       status_ff, status_in;
   logic [KEY_W-1:0] value_ff, value_in;
   logic [1:0]       rsp_status_ff;
   logic [KEY_W-1:0] rsp_value_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

   // result moves to the output register once that register is free
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      value_in  = value_ff;
      cmd       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_BKT;
            end
         end
         S_BKT: begin
            cmd.bkt = 1'b1; state_in = S_HEAD;
         end
         S_HEAD: begin
            // head and free-top reads now valid
            value_in = '0;
            priority if (op_q == OP_INSERT) begin
               if (sts.pool_empty) begin
                  status_in = ST_FULL; state_in = S_RESP;
               end else state_in = S_INSERT;
            end else if (op_q == OP_NONE) begin
               status_in = ST_NOTFOUND; state_in = S_RESP;
            end else begin
               cmd.rd_node = 1'b1; state_in = S_CUR;
            end
         end
         S_INSERT: begin
            cmd.ins = 1'b1; status_in = ST_DONE; state_in = S_RESP;
         end
         S_CUR: begin
            // node memories read at cur
            if (sts.cur_nil || sts.walk_limit) begin
               status_in = ST_NOTFOUND; state_in = S_RESP;
            end else state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.match) begin
               if (op_q == OP_SEARCH) begin
                  status_in = ST_FOUND; value_in = key_q;
               end else begin
                  cmd.del = 1'b1; status_in = ST_DONE;
               end
               state_in = S_RESP;
            end else begin
               cmd.step = 1'b1; state_in = S_CUR;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= value_ff;
      end
   end

   `CHT_ASSERT_IMPL(a_no_accept_busy, clock, reset,
      (req_valid && req_ready) |=> !req_ready, "accept while busy")
   `CHT_ASSERT_IMPL(a_resp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status), "response dropped")
   `CHT_ASSERT_IMPL(a_value_zero, clock, reset,
      (rsp_valid && rsp_status != ST_FOUND) |-> rsp_found_value == '0, "value not zero")
   `CHT_ASSERT_IMPL(a_ins_free, clock, reset,
      cmd.ins |-> !sts.pool_empty, "insert into empty pool")
endmodule

@@ src/chained_hash_table.sv @@
// Flow: an accepted word hashes its key to a bucket and reads the head; insert links a free
// node at the head, search and delete walk the chain, refused insert or unknown op go to the result.
// Throughput: one word at a time; the next word is taken once the result is
// registered, and a result still held by the receiver stalls the one behind it.
// Reset: synchronous; a clearing pass then empties
// the bucket heads and refills the free stack before the first accept.
module chained_hash_table #(
   parameter int BUCKETS    = cht_pkg::DEF_BUCKETS,
   parameter int POOL_NODES = cht_pkg::DEF_POOL_NODES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic [cht_pkg::KEY_W-1:0] req_key,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [cht_pkg::KEY_W-1:0] rsp_found_value
);
   import cht_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic [1:0]       op_q;
   logic [KEY_W-1:0] key_q;

   cht_datapath #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
      .clock, .reset, .req_operation, .req_key, .cmd, .sts, .op_q, .key_q);

   cht_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_status, .rsp_found_value, .op_q, .key_q, .sts, .cmd);
endmodule

@@ tb/sv/chained_hash_table_checker.sv @@
module chained_hash_table_checker
   import cht_pkg::*;
#(
   parameter int BUCKETS    = DEF_BUCKETS,
   parameter int POOL_NODES = DEF_POOL_NODES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [1:0]       req_operation,
   input  logic [KEY_W-1:0] req_key,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [1:0]       rsp_status,
   input  logic [KEY_W-1:0] rsp_found_value,
   output int               fail_count,
   output int               pending,
   output int               rsp_seen,
   output int               hit_count,
   output int               full_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NIL = POOL_NODES;

   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] value;
   } answer_type;

   // shadow copy of the table
   int               head_q [BUCKETS];
   logic [KEY_W-1:0] key_mem [POOL_NODES];
   int               link_mem [POOL_NODES];
   int               free_stk [POOL_NODES];
   int               free_num;
   answer_type       answers [$];

   function automatic answer_type apply_request(op_type op, logic [KEY_W-1:0] key);
      answer_type a;
      int b, cur, prev, n;
      a.status = ST_NOTFOUND;
      a.value  = '0;
      b = key % BUCKETS;
      case (op)
         OP_INSERT: begin
            if (free_num == 0) begin
               a.status = ST_FULL;
            end else begin
               free_num--;
               n = free_stk[free_num];
               key_mem[n]  = key;
               link_mem[n] = head_q[b];
               head_q[b]   = n;
               a.status    = ST_DONE;
            end
         end
         OP_SEARCH: begin
            cur = head_q[b];
            for (int s = 0; s < POOL_NODES && cur != NIL; s++) begin
               if (key_mem[cur] == key) begin
                  a.status = ST_FOUND;
                  a.value  = key;
                  break;
               end
               cur = link_mem[cur];
            end
         end
         OP_DELETE: begin
            prev = NIL;
            cur  = head_q[b];
            for (int s = 0; s < POOL_NODES && cur != NIL; s++) begin
               if (key_mem[cur] == key) begin
                  if (prev == NIL) head_q[b] = link_mem[cur];
                  else link_mem[prev] = link_mem[cur];
                  link_mem[cur] = NIL;
                  if (free_num < POOL_NODES) begin
                     free_stk[free_num] = cur;
                     free_num++;
                  end
                  a.status = ST_DONE;
                  break;
               end
               prev = cur;
               cur  = link_mem[cur];
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         for (int i = 0; i < BUCKETS; i++) head_q[i] = NIL;
         for (int i = 0; i < POOL_NODES; i++) begin
            link_mem[i] = NIL;
            free_stk[i] = i;
         end
         free_num = POOL_NODES;
         answers.delete();
         fail_count = 0;
         rsp_seen   = 0;
         hit_count  = 0;
         full_count = 0;
      end else begin
         // predict on accepted request words
         if (req_valid && req_ready) begin
            a = apply_request(op_type'(req_operation), req_key);
            answers.push_back(a);
         end
         // compare accepted result words
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (answers.size() == 0) begin
               $error("unexpected result word status=%0d", rsp_status);
               fail_count++;
            end else begin
               a = answers.pop_front();
               if (a.status == ST_FOUND) hit_count++;
               if (a.status == ST_FULL) full_count++;
               if (rsp_status !== a.status) begin
                  $error("status: expected %0d, actual %0d", a.status, rsp_status);
                  fail_count++;
               end
               if (rsp_found_value !== a.value) begin
                  $error("found_value: expected %0d, actual %0d", a.value,
                         rsp_found_value);
                  fail_count++;
               end
            end
         end
      end
      pending = answers.size();
   end
endmodule

@@ tb/sv/chained_hash_table_tb.sv @@
module chained_hash_table_tb;
   import cht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAND_WORDS = 1400;
   localparam int WD_LIMIT   = 20000;

   logic             clock, reset;
   logic             req_valid, req_ready;
   logic [1:0]       req_operation;
   logic [KEY_W-1:0] req_key;
   logic             rsp_valid, rsp_ready;
   logic [1:0]       rsp_status;
   logic [KEY_W-1:0] rsp_found_value;
   int               fail_count, pending, rsp_seen, hit_count, full_count;
   int               idle_cycles;
   int               sent;
   logic [KEY_W-1:0] key_pool [32];

   chained_hash_table dut (.*);

   chained_hash_table_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stall pattern: calm stretches and busy stretches
   initial begin
      int mode;
      rsp_ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // watchdog on accept activity
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("chained_hash_table_tb: done, errors");
         $finish;
      end
   end

   // present one word and hold it until accepted
   task automatic send_word(op_type op, logic [KEY_W-1:0] key);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic go_idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst, r;
      op_type op;
      logic [KEY_W-1:0] k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_INSERT;
      req_key = '0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, duplicates, unknown op
      send_word(OP_SEARCH, '0);
      send_word(OP_DELETE, '1);
      send_word(OP_INSERT, '0);
      send_word(OP_INSERT, '1);
      send_word(OP_INSERT, 31'h10);
      send_word(OP_INSERT, 31'h10);
      send_word(OP_SEARCH, '0);
      send_word(OP_SEARCH, '1);
      send_word(OP_SEARCH, 31'h20);
      send_word(OP_DELETE, 31'h10);
      send_word(OP_SEARCH, 31'h10);
      send_word(OP_DELETE, 31'h10);
      send_word(OP_DELETE, 31'h10);
      send_word(OP_NONE, '1);
      send_word(OP_NONE, '0);
      send_word(OP_DELETE, '0);
      send_word(OP_DELETE, '1);
      go_idle(1);
      // fill the pool to overflow, then drain it, all in one bucket
      for (int i = 0; i < 66; i++) send_word(OP_INSERT, 31'(i * 16 + 5));
      send_word(OP_SEARCH, 31'h5);
      for (int i = 0; i < 64; i++) send_word(OP_DELETE, 31'(i * 16 + 5));

      // random: small key set so hits, chains and full pool all occur
      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom());
      key_pool[0] = '1;
      key_pool[1] = '0;
      while (sent < RAND_WORDS + 150) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst; j++) begin
            r = $urandom_range(0, 99);
            if (r < 45) op = OP_INSERT;
            else if (r < 70) op = OP_SEARCH;
            else if (r < 97) op = OP_DELETE;
            else op = OP_NONE;
            if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom());
            else k = key_pool[$urandom_range(0, 31)];
            send_word(op, k);
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 30));
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("%0d request words, %0d results checked", sent, rsp_seen);
      $display("%0d search hits, %0d inserts refused on full pool", hit_count, full_count);
      if (fail_count == 0) begin
         $display("chained_hash_table_tb: done, clean");
      end else begin
         $display("chained_hash_table_tb: done, errors");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+src
src/cht_pkg.sv
src/cht_ram.sv
src/cht_datapath.sv
src/cht_ctrl.sv
src/chained_hash_table.sv
tb/sv/chained_hash_table_checker.sv
tb/sv/chained_hash_table_tb.sv
